// ===== rtl/horspool_substring_search_unit_macros.svh =====
// assertion macros used by the checker of the search unit
`ifndef HORSPOOL_SUBSTRING_SEARCH_UNIT_MACROS_SVH
`define HORSPOOL_SUBSTRING_SEARCH_UNIT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define HSSS_AST_SAME(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("hsss assertion failed");

// condition holds in the cycle after the trigger
`define HSSS_AST_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("hsss assertion failed");

`endif

// ===== rtl/hsss_pkg.sv =====
`default_nettype none

package hsss_pkg;

	localparam int ALPHABET = 256;
	localparam int BYTE_W   = 8;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_BUILD_RD,
		ST_BUILD_WR,
		ST_CMP_RD,
		ST_CMP_CHK,
		ST_SH_RD,
		ST_SH_ADD
	} state_t;

	// datapath commands, one per cycle
	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_INIT,
		DP_BUILD_RD,
		DP_BUILD_WR,
		DP_CMP_RD,
		DP_CMP_STEP,
		DP_TEXT_TAIL,
		DP_SHIFT_LOOK,
		DP_SHIFT_ADD,
		DP_FINISH_HIT,
		DP_FINISH_MISS
	} dp_op_t;

	// datapath status back to the controller
	typedef struct packed {
		logic m_gt_n;
		logic lastp_zero;
		logic build_last;
		logic eq;
		logic k_zero;
		logic past_end;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/horspool_substring_search_unit.sv =====
// channel  | signals                                      | handshake
// ---------+----------------------------------------------+--------------------------
// input    | command, data_byte, last_byte                | taken when start & !busy
// result   | found, match_position, capacity_exceeded     | valid while done is high
//
// a text byte or a non-final pattern byte is taken without raising busy
// a final pattern byte starts a search: an init step, a read and a write per pattern
// byte but the last to build the shift table, then per window a read, a compare per
// character and a lookup and an add when the window shifts; done pulses in the first cycle with busy low
// reset clears lengths and flags and starts a new text; memories keep no reset
// results are shown for one cycle only, the receiver cannot stall them
`default_nettype none

module horspool_substring_search_unit
	import hsss_pkg::*;
#(
	parameter int TEXT_MAX = 256,
	parameter int PAT_MAX  = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              command,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              last_byte,
	output logic                   done,
	output logic                   found,
	output logic [BYTE_W-1:0]      match_position,
	output logic                   capacity_exceeded
);

	dp_op_t     op;
	dp_status_t status;

	// sequencer
	hsss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.command   (command),
		.last_byte (last_byte),
		.status    (status),
		.busy      (busy),
		.op        (op)
	);

	// buffers, shift table and compare logic
	hsss_datapath #(
		.TEXT_MAX (TEXT_MAX),
		.PAT_MAX  (PAT_MAX)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.op                (op),
		.command           (command),
		.data_byte         (data_byte),
		.last_byte         (last_byte),
		.status            (status),
		.done              (done),
		.found             (found),
		.match_position    (match_position),
		.capacity_exceeded (capacity_exceeded)
	);

endmodule

`default_nettype wire

// ===== rtl/hsss_datapath.sv =====
`default_nettype none

module hsss_datapath
	import hsss_pkg::*;
#(
	parameter int TEXT_MAX = 256,
	parameter int PAT_MAX  = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_op_t            op,
	input  wire logic              command,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              last_byte,
	output dp_status_t             status,
	output logic                   done,
	output logic                   found,
	output logic [BYTE_W-1:0]      match_position,
	output logic                   capacity_exceeded
);

	localparam int LW  = $clog2(TEXT_MAX + 1);
	localparam int AW  = $clog2(TEXT_MAX);
	localparam int PLW = $clog2(PAT_MAX + 1);
	localparam int PAW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
	localparam int EW  = ((LW > PLW) ? LW : PLW) + 2;

	logic [BYTE_W-1:0] text_mem  [TEXT_MAX];
	logic [BYTE_W-1:0] pat_mem   [PAT_MAX];
	logic [PLW-1:0]    shift_mem [ALPHABET];

	logic [LW-1:0]       tlen_q;
	logic                tovf_q;
	logic                tnew_q;
	logic [PLW-1:0]      plen_q;
	logic                povf_q;
	logic [PAW-1:0]      i_q;
	logic [PAW-1:0]      k_q;
	logic [LW-1:0]       off_q;
	logic [ALPHABET-1:0] sh_vld_q;

	logic [BYTE_W-1:0] text_rd_q;
	logic [BYTE_W-1:0] pat_rd_q;
	logic [PLW-1:0]    sh_rd_q;
	logic              sh_vld_rd_q;

	logic              done_q;
	logic              found_q;
	logic [BYTE_W-1:0] pos_q;
	logic              cap_q;

	logic [LW-1:0]        teff;
	logic                 text_ok;
	logic                 pat_ok;
	logic [PLW-1:0]       lastp_w;
	logic [PAW-1:0]       lastp_a;
	logic [PAW-1:0]       k_dec;
	logic [PAW-1:0]       k_sel;
	logic [EW-1:0]        taddr_e;
	logic [AW-1:0]        text_raddr;
	logic [PAW-1:0]       pat_raddr;
	logic [PLW-1:0]       shift_val;
	logic [EW-1:0]        next_off_e;
	logic [LW+BYTE_W-1:0] off_ext;

	// load bookkeeping
	assign teff    = tnew_q ? '0 : tlen_q;
	assign text_ok = EW'(teff) < EW'(TEXT_MAX);
	assign pat_ok  = EW'(plen_q) < EW'(PAT_MAX);

	// pattern geometry
	assign lastp_w = plen_q - PLW'(1);
	assign lastp_a = lastp_w[PAW-1:0];
	assign k_dec   = k_q - PAW'(1);

	// text read address
	always_comb begin
		case (op)
			DP_CMP_STEP:  k_sel = k_dec;
			DP_TEXT_TAIL: k_sel = lastp_a;
			default:      k_sel = k_q;
		endcase
	end
	assign taddr_e    = EW'(off_q) + EW'(k_sel);
	assign text_raddr = taddr_e[AW-1:0];

	// pattern read address
	always_comb begin
		case (op)
			DP_BUILD_RD: pat_raddr = i_q;
			DP_CMP_STEP: pat_raddr = k_dec;
			default:     pat_raddr = k_q;
		endcase
	end

	// shift for the current window, entries not set by the pattern give m
	assign shift_val  = sh_vld_rd_q ? sh_rd_q : plen_q;
	assign next_off_e = EW'(off_q) + EW'(shift_val);
	assign off_ext    = {{BYTE_W{1'b0}}, off_q};

	// status to the controller
	always_comb begin
		status.m_gt_n     = EW'(plen_q) > EW'(tlen_q);
		status.lastp_zero = lastp_w == '0;
		status.build_last = (PLW'(i_q) + PLW'(1)) == lastp_w;
		status.eq         = pat_rd_q == text_rd_q;
		status.k_zero     = k_q == '0;
		status.past_end   = (next_off_e + EW'(plen_q)) > EW'(tlen_q);
	end

	// text memory
	always_ff @(posedge clk) begin
		if (op == DP_LOAD && !command && text_ok) begin
			text_mem[teff[AW-1:0]] <= data_byte;
		end
		text_rd_q <= text_mem[text_raddr];
	end

	// pattern memory
	always_ff @(posedge clk) begin
		if (op == DP_LOAD && command && pat_ok) begin
			pat_mem[plen_q[PAW-1:0]] <= data_byte;
		end
		pat_rd_q <= pat_mem[pat_raddr];
	end

	// bad-character shift memory
	always_ff @(posedge clk) begin
		if (op == DP_BUILD_WR) begin
			shift_mem[pat_rd_q] <= lastp_w - PLW'(i_q);
		end
		sh_rd_q     <= shift_mem[text_rd_q];
		sh_vld_rd_q <= sh_vld_q[text_rd_q];
	end

	// lengths, search indexes and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q   <= '0;
			tovf_q   <= 1'b0;
			tnew_q   <= 1'b1;
			plen_q   <= '0;
			povf_q   <= 1'b0;
			i_q      <= '0;
			k_q      <= '0;
			off_q    <= '0;
			sh_vld_q <= '0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			pos_q    <= '0;
			cap_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (op) inside
				DP_LOAD: begin
					if (!command) begin
						tnew_q <= last_byte;
						if (tnew_q) begin
							tovf_q <= 1'b0;
						end
						if (text_ok) begin
							tlen_q <= teff + LW'(1);
						end else begin
							tovf_q <= 1'b1;
						end
					end else if (pat_ok) begin
						plen_q <= plen_q + PLW'(1);
					end else begin
						povf_q <= 1'b1;
					end
				end
				DP_INIT: begin
					i_q      <= '0;
					off_q    <= '0;
					k_q      <= lastp_a;
					sh_vld_q <= '0;
				end
				DP_BUILD_WR: begin
					i_q                <= i_q + PAW'(1);
					sh_vld_q[pat_rd_q] <= 1'b1;
				end
				DP_CMP_STEP: begin
					k_q <= k_dec;
				end
				DP_SHIFT_ADD: begin
					off_q <= next_off_e[LW-1:0];
					k_q   <= lastp_a;
				end
				DP_FINISH_HIT, DP_FINISH_MISS: begin
					done_q  <= 1'b1;
					found_q <= op == DP_FINISH_HIT;
					pos_q   <= (op == DP_FINISH_HIT) ? off_ext[BYTE_W-1:0] : '0;
					cap_q   <= tovf_q | povf_q;
					plen_q  <= '0;
					povf_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign done              = done_q;
	assign found             = found_q;
	assign match_position    = pos_q;
	assign capacity_exceeded = cap_q;

endmodule

`default_nettype wire

// ===== rtl/hsss_ctrl.sv =====
`default_nettype none

module hsss_ctrl
	import hsss_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       command,
	input  wire logic       last_byte,
	input  wire dp_status_t status,
	output logic            busy,
	output dp_op_t          op
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && command && last_byte) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				if (status.m_gt_n) begin
					state_d = ST_IDLE;
				end else if (status.lastp_zero) begin
					state_d = ST_CMP_RD;
				end else begin
					state_d = ST_BUILD_RD;
				end
			end
			ST_BUILD_RD: state_d = ST_BUILD_WR;
			ST_BUILD_WR: begin
				state_d = status.build_last ? ST_CMP_RD : ST_BUILD_RD;
			end
			ST_CMP_RD: state_d = ST_CMP_CHK;
			ST_CMP_CHK: begin
				if (status.eq && status.k_zero) begin
					state_d = ST_IDLE;
				end else if (!status.eq) begin
					state_d = ST_SH_RD;
				end
			end
			ST_SH_RD: state_d = ST_SH_ADD;
			ST_SH_ADD: begin
				state_d = status.past_end ? ST_IDLE : ST_CMP_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath command
	always_comb begin
		op = DP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op = DP_LOAD;
				end
			end
			ST_INIT:     op = status.m_gt_n ? DP_FINISH_MISS : DP_INIT;
			ST_BUILD_RD: op = DP_BUILD_RD;
			ST_BUILD_WR: op = DP_BUILD_WR;
			ST_CMP_RD:   op = DP_CMP_RD;
			ST_CMP_CHK: begin
				if (status.eq && status.k_zero) begin
					op = DP_FINISH_HIT;
				end else if (status.eq) begin
					op = DP_CMP_STEP;
				end else begin
					op = DP_TEXT_TAIL;
				end
			end
			ST_SH_RD:  op = DP_SHIFT_LOOK;
			ST_SH_ADD: op = status.past_end ? DP_FINISH_MISS : DP_SHIFT_ADD;
			default:   op = DP_NONE;
		endcase
	end

	assign busy = state_q != ST_IDLE;

endmodule

`default_nettype wire

// ===== rtl/hsss_checker.sv =====
`default_nettype none

`include "horspool_substring_search_unit_macros.svh"

module hsss_checker
	import hsss_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              command,
	input wire logic              last_byte,
	input wire logic              done,
	input wire logic              found,
	input wire logic [BYTE_W-1:0] match_position
);

	// a result is a single-cycle pulse
	`HSSS_AST_NEXT(a_done_pulse, clk, arst_n, done, !done)

	// a miss reports offset zero
	`HSSS_AST_SAME(a_miss_pos, clk, arst_n, done && !found, match_position == '0)

	// a final pattern byte starts a search
	`HSSS_AST_NEXT(a_search_starts, clk, arst_n, start && !busy && command && last_byte, busy)

	// a text byte never stalls the input
	`HSSS_AST_NEXT(a_text_no_stall, clk, arst_n, start && !busy && !command, !busy)

	// a result only follows a search
	`HSSS_AST_SAME(a_done_after_busy, clk, arst_n, done, $past(busy))

endmodule

bind horspool_substring_search_unit hsss_checker u_hsss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.command        (command),
	.last_byte      (last_byte),
	.done           (done),
	.found          (found),
	.match_position (match_position)
);

`default_nettype wire
